/* hdl/assert_macros.svh */
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, off while rstn is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property against the module's own clk_i and rst_ni.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* hdl/phfe_pkg.sv */
package phfe_pkg;

  localparam int unsigned ETH_WIN = 6;
  localparam int unsigned L3_WIN  = 10;
  localparam int unsigned L4_WIN  = 13;

  localparam logic [7:0]  ETH_TYPE_OFF    = 8'd12;
  localparam logic [7:0]  VLAN_TCI_OFF    = 8'd14;
  localparam logic [7:0]  VLAN_TYPE_OFF   = 8'd16;
  localparam logic [4:0]  L3_OFF_ETH      = 5'd14;
  localparam logic [4:0]  L3_OFF_VLAN     = 5'd18;
  localparam logic [6:0]  IPV6_HDR_LEN    = 7'd40;
  localparam logic [7:0]  OFF_MAX         = 8'd255;

  localparam logic [15:0] ETH_TYPE_VLAN   = 16'h8100;
  localparam logic [15:0] ETH_TYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6   = 16'h86DD;

  localparam logic [7:0]  IP_VER_4        = 8'd4;
  localparam logic [7:0]  IP_VER_6        = 8'd6;

  localparam logic [7:0]  IP_PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  IP_PROTO_TCP    = 8'd6;
  localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
  localparam logic [7:0]  IP_PROTO_ICMPV6 = 8'd58;

  localparam logic [7:0]  ICMP_ECHO_REPLY    = 8'd0;
  localparam logic [7:0]  ICMP_ECHO_REQ      = 8'd8;
  localparam logic [7:0]  ICMPV6_ECHO_REQ    = 8'd128;
  localparam logic [7:0]  ICMPV6_ECHO_RSP    = 8'd129;

  localparam logic [15:0] UDP_HDR_LEN     = 16'd8;

  typedef enum logic [1:0] {
    L3_NONE,
    L3_IPV4,
    L3_IPV6
  } l3_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       framing;
  } beat_t;

  typedef struct packed {
    logic                         mode;
    logic [7:0]                   cnt;
    logic [ETH_WIN-1:0][7:0]      eth;
    logic [L3_WIN-1:0][7:0]       l3w;
    logic [L4_WIN-1:0][7:0]       l4w;
  } snap_t;

  typedef struct packed {
    logic [7:0]  ip_version;
    logic [7:0]  l4_protocol;
    logic [15:0] ipv4_ident;
    logic [16:0] total_length;
    logic [15:0] payload_length;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] l4_ident;
    logic [31:0] l4_second;
    logic [7:0]  icmp_kind;
    logic [15:0] vlan_tag;
    logic [15:0] ether_type;
  } record_t;

  function automatic logic [4:0] l3_start_f(input logic mode, input logic [15:0] outer_type);
    logic [4:0] start;
    start = '0;
    if (mode) begin
      start = (outer_type == ETH_TYPE_VLAN) ? L3_OFF_VLAN : L3_OFF_ETH;
    end
    return start;
  endfunction

  function automatic l3_kind_e l3_kind_f(input logic mode, input logic [15:0] outer_type,
                                         input logic [15:0] inner_type,
                                         input logic [7:0] ip_b0);
    logic [15:0] etype;
    l3_kind_e    kind;
    etype = (outer_type == ETH_TYPE_VLAN) ? inner_type : outer_type;
    kind  = L3_NONE;
    if (mode) begin
      if (etype == ETH_TYPE_IPV4) begin
        kind = L3_IPV4;
      end else if (etype == ETH_TYPE_IPV6) begin
        kind = L3_IPV6;
      end
    end else begin
      if (ip_b0[7:4] == IP_VER_4[3:0]) begin
        kind = L3_IPV4;
      end else if (ip_b0[7:4] == IP_VER_6[3:0]) begin
        kind = L3_IPV6;
      end
    end
    return kind;
  endfunction

  function automatic logic [6:0] l4_start_f(input l3_kind_e kind, input logic [4:0] l3s,
                                            input logic [7:0] ip_b0);
    logic [6:0] start;
    if (kind == L3_IPV6) begin
      start = {2'b00, l3s} + IPV6_HDR_LEN;
    end else begin
      start = {2'b00, l3s} + {1'b0, ip_b0[3:0], 2'b00};
    end
    return start;
  endfunction

endpackage

/* hdl/packet_header_field_extractor.sv */
// Packet header field extractor.
// Input channel: one packet byte per beat (in_valid_i / in_stall_o) with
// first/last marks and the framing bit, sampled on the first beat
// (0: packet opens at the IP header, 1: packet opens at the Ethernet header).
// Output channel: one record per beat marked last (out_valid_o / out_stall_i),
// carrying the L2/L3/L4 fields reached so far; fields not reached read zero.
// Throughput: one byte per cycle while in_stall_o is low; every beat updates a
// set of small capture windows (Ethernet type/tag, first ten L3 bytes, first
// thirteen L4 bytes) and the record is formed from them in the same cycle.
// A last beat is held in the input register, then its record in the output one.
// The input register keeps taking beats while a record waits at the output;
// only a last beat that meets a stalled, occupied output register holds the
// input stage, which then raises in_stall_o.
// Reset clears both stages, the byte count and the captured windows; bytes
// before any first mark are parsed with IP framing.
`include "assert_macros.svh"

module packet_header_field_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic        framing_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  ip_version_o,
  output logic [7:0]  l4_protocol_o,
  output logic [15:0] ipv4_ident_o,
  output logic [16:0] total_length_o,
  output logic [15:0] payload_length_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [31:0] l4_ident_o,
  output logic [31:0] l4_second_o,
  output logic [7:0]  icmp_kind_o,
  output logic [15:0] vlan_tag_o,
  output logic [15:0] ether_type_o
);
  import phfe_pkg::*;

  beat_t   in_q, in_d;
  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  record_t rec_q, rec_d;
  snap_t   snap;
  logic    accept;
  logic    out_free;
  logic    adv;
  logic    load_out;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && (!in_q.last_byte || out_free);
  assign load_out   = adv && in_q.last_byte;
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_d.data_byte  = data_byte_i;
    in_d.first_byte = first_byte_i;
    in_d.last_byte  = last_byte_i;
    in_d.framing    = framing_i;
    in_valid_d      = accept ? 1'b1 : (adv ? 1'b0 : in_valid_q);
    out_valid_d     = load_out ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  end

  phfe_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .beat_i (in_q),
    .snap_o (snap)
  );

  phfe_decode u_decode (
    .snap_i (snap),
    .rec_o  (rec_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_d;
    end
    if (load_out) begin
      rec_q <= rec_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ip_version_o     = rec_q.ip_version;
  assign l4_protocol_o    = rec_q.l4_protocol;
  assign ipv4_ident_o     = rec_q.ipv4_ident;
  assign total_length_o   = rec_q.total_length;
  assign payload_length_o = rec_q.payload_length;
  assign source_port_o    = rec_q.source_port;
  assign dest_port_o      = rec_q.dest_port;
  assign l4_ident_o       = rec_q.l4_ident;
  assign l4_second_o      = rec_q.l4_second;
  assign icmp_kind_o      = rec_q.icmp_kind;
  assign vlan_tag_o       = rec_q.vlan_tag;
  assign ether_type_o     = rec_q.ether_type;

  `ASSERT_STD(a_no_overwrite, out_valid_q && out_stall_i |-> !load_out,
              "record overwritten while stalled")
  `ASSERT_STD(a_load_shows, load_out |=> out_valid_q, "loaded record not presented")
  `ASSERT_STD(a_hold_beat, in_valid_q && !adv |=> in_valid_q && $stable(in_q),
              "held input beat lost")

endmodule

/* hdl/phfe_capture.sv */
`include "assert_macros.svh"

module phfe_capture (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  phfe_pkg::beat_t beat_i,
  output phfe_pkg::snap_t snap_o
);
  import phfe_pkg::*;

  logic                    mode_q, mode_d;
  logic [7:0]              off_q, off_d;
  logic [ETH_WIN-1:0][7:0] eth_q, eth_b, eth_d;
  logic [L3_WIN-1:0][7:0]  l3w_q, l3w_b, l3w_d;
  logic [L4_WIN-1:0][7:0]  l4w_q, l4w_b, l4w_d;
  logic [7:0]              off_eff;
  logic [4:0]              l3s;
  logic [6:0]              l4s;
  logic [7:0]              l3b0;
  l3_kind_e                kind;

  always_comb begin
    off_eff = beat_i.first_byte ? '0 : off_q;
    mode_d  = beat_i.first_byte ? beat_i.framing : mode_q;
    eth_b   = beat_i.first_byte ? '0 : eth_q;
    l3w_b   = beat_i.first_byte ? '0 : l3w_q;
    l4w_b   = beat_i.first_byte ? '0 : l4w_q;
    off_d   = (off_eff == OFF_MAX) ? OFF_MAX : off_eff + 8'd1;

    l3s  = l3_start_f(mode_d, {eth_b[0], eth_b[1]});
    l3b0 = (off_eff == {3'b000, l3s}) ? beat_i.data_byte : l3w_b[0];
    kind = l3_kind_f(mode_d, {eth_b[0], eth_b[1]}, {eth_b[4], eth_b[5]}, l3b0);
    l4s  = l4_start_f(kind, l3s, l3b0);

    eth_d = eth_b;
    for (int i = 0; i < ETH_WIN; i++) begin
      if (off_eff == ETH_TYPE_OFF + 8'(i)) begin
        eth_d[i] = beat_i.data_byte;
      end
    end
    l3w_d = l3w_b;
    for (int i = 0; i < L3_WIN; i++) begin
      if (off_eff == {3'b000, l3s} + 8'(i)) begin
        l3w_d[i] = beat_i.data_byte;
      end
    end
    l4w_d = l4w_b;
    for (int i = 0; i < L4_WIN; i++) begin
      if (off_eff == {1'b0, l4s} + 8'(i)) begin
        l4w_d[i] = beat_i.data_byte;
      end
    end

    snap_o.mode = mode_d;
    snap_o.cnt  = off_d;
    snap_o.eth  = eth_d;
    snap_o.l3w  = l3w_d;
    snap_o.l4w  = l4w_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      off_q  <= '0;
      eth_q  <= '0;
      l3w_q  <= '0;
      l4w_q  <= '0;
    end else if (adv_i) begin
      mode_q <= mode_d;
      off_q  <= off_d;
      eth_q  <= eth_d;
      l3w_q  <= l3w_d;
      l4w_q  <= l4w_d;
    end
  end

  `ASSERT_STD(a_cnt_nonzero, adv_i |=> off_q != 8'd0, "byte count wrapped to zero")
  `ASSERT_STD(a_first_restart, adv_i && beat_i.first_byte |=> off_q == 8'd1,
              "first beat did not restart the byte count")

endmodule

/* hdl/phfe_decode.sv */
module phfe_decode (
  input  phfe_pkg::snap_t   snap_i,
  output phfe_pkg::record_t rec_o
);
  import phfe_pkg::*;

  function automatic logic got_f(input logic [7:0] cnt, input logic [7:0] off,
                                 input logic [2:0] n);
    return ({1'b0, off} + {6'b0, n}) <= {1'b0, cnt};
  endfunction

  record_t    rec;
  l3_kind_e   kind;
  logic [4:0] l3s;
  logic [6:0] l4s;
  logic [7:0] l3o;
  logic [7:0] l4o;
  logic       l3_ok;
  logic       l4_ok;
  logic       proto_ok;
  logic       pay_ok;
  logic       echo;

  always_comb begin
    rec      = '0;
    kind     = L3_NONE;
    l3s      = '0;
    l4s      = '0;
    l3_ok    = 1'b0;
    l4_ok    = 1'b0;
    proto_ok = 1'b0;
    pay_ok   = 1'b0;
    echo     = 1'b0;

    if (snap_i.mode) begin
      if (got_f(snap_i.cnt, ETH_TYPE_OFF, 3'd2)) begin
        if ({snap_i.eth[0], snap_i.eth[1]} == ETH_TYPE_VLAN) begin
          if (got_f(snap_i.cnt, VLAN_TCI_OFF, 3'd2)) begin
            rec.vlan_tag = {snap_i.eth[2], snap_i.eth[3]};
          end
          if (got_f(snap_i.cnt, VLAN_TYPE_OFF, 3'd2)) begin
            rec.ether_type = {snap_i.eth[4], snap_i.eth[5]};
            l3_ok          = 1'b1;
          end
        end else begin
          rec.ether_type = {snap_i.eth[0], snap_i.eth[1]};
          l3_ok          = 1'b1;
        end
      end
    end else if (got_f(snap_i.cnt, 8'd0, 3'd1)) begin
      l3_ok = 1'b1;
    end

    if (l3_ok) begin
      l3s  = l3_start_f(snap_i.mode, {snap_i.eth[0], snap_i.eth[1]});
      kind = l3_kind_f(snap_i.mode, {snap_i.eth[0], snap_i.eth[1]},
                       {snap_i.eth[4], snap_i.eth[5]}, snap_i.l3w[0]);
      if (!snap_i.mode && kind == L3_NONE) begin
        rec.ip_version = snap_i.l3w[0];
      end
    end
    l3o = {3'b000, l3s};
    l4s = l4_start_f(kind, l3s, snap_i.l3w[0]);
    l4o = {1'b0, l4s};

    unique case (kind)
      L3_IPV4: begin
        rec.ip_version = IP_VER_4;
        l4_ok = got_f(snap_i.cnt, l3o, 3'd1);
        if (got_f(snap_i.cnt, l3o + 8'd9, 3'd1)) begin
          rec.l4_protocol = snap_i.l3w[9];
          proto_ok        = 1'b1;
        end
        if (got_f(snap_i.cnt, l3o + 8'd4, 3'd2)) begin
          rec.ipv4_ident = {snap_i.l3w[4], snap_i.l3w[5]};
        end
        if (got_f(snap_i.cnt, l3o + 8'd2, 3'd2)) begin
          rec.total_length   = {1'b0, snap_i.l3w[2], snap_i.l3w[3]};
          rec.payload_length = {snap_i.l3w[2], snap_i.l3w[3]}
                             - {10'b0, snap_i.l3w[0][3:0], 2'b00};
          pay_ok             = 1'b1;
        end
      end
      L3_IPV6: begin
        rec.ip_version = IP_VER_6;
        l4_ok = 1'b1;
        if (got_f(snap_i.cnt, l3o + 8'd6, 3'd1)) begin
          rec.l4_protocol = snap_i.l3w[6];
          proto_ok        = 1'b1;
        end
        if (got_f(snap_i.cnt, l3o + 8'd4, 3'd2)) begin
          rec.payload_length = {snap_i.l3w[4], snap_i.l3w[5]};
          rec.total_length   = {1'b0, snap_i.l3w[4], snap_i.l3w[5]} + 17'(IPV6_HDR_LEN);
          pay_ok             = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (l4_ok && proto_ok) begin
      case (rec.l4_protocol) inside
        IP_PROTO_TCP: begin
          if (got_f(snap_i.cnt, l4o, 3'd2)) begin
            rec.source_port = {snap_i.l4w[0], snap_i.l4w[1]};
          end
          if (got_f(snap_i.cnt, l4o + 8'd2, 3'd2)) begin
            rec.dest_port = {snap_i.l4w[2], snap_i.l4w[3]};
          end
          if (got_f(snap_i.cnt, l4o + 8'd4, 3'd4)) begin
            rec.l4_ident = {snap_i.l4w[4], snap_i.l4w[5], snap_i.l4w[6], snap_i.l4w[7]};
          end
          if (got_f(snap_i.cnt, l4o + 8'd8, 3'd4)) begin
            rec.l4_second = {snap_i.l4w[8], snap_i.l4w[9], snap_i.l4w[10], snap_i.l4w[11]};
          end
          if (pay_ok && got_f(snap_i.cnt, l4o + 8'd12, 3'd1)) begin
            rec.payload_length = rec.payload_length - {10'b0, snap_i.l4w[12][7:4], 2'b00};
          end
        end
        IP_PROTO_UDP: begin
          if (got_f(snap_i.cnt, l4o, 3'd2)) begin
            rec.source_port = {snap_i.l4w[0], snap_i.l4w[1]};
          end
          if (got_f(snap_i.cnt, l4o + 8'd2, 3'd2)) begin
            rec.dest_port = {snap_i.l4w[2], snap_i.l4w[3]};
          end
          if (pay_ok) begin
            rec.payload_length = rec.payload_length - UDP_HDR_LEN;
          end
        end
        IP_PROTO_ICMP, IP_PROTO_ICMPV6: begin
          if (got_f(snap_i.cnt, l4o, 3'd1)) begin
            rec.icmp_kind = snap_i.l4w[0];
            echo = (snap_i.l4w[0] == ICMP_ECHO_REPLY) || (snap_i.l4w[0] == ICMP_ECHO_REQ)
                || (snap_i.l4w[0] == ICMPV6_ECHO_REQ) || (snap_i.l4w[0] == ICMPV6_ECHO_RSP);
            if (echo && got_f(snap_i.cnt, l4o + 8'd4, 3'd2)) begin
              rec.l4_ident = {16'b0, snap_i.l4w[4], snap_i.l4w[5]};
            end
            if (echo && got_f(snap_i.cnt, l4o + 8'd6, 3'd2)) begin
              rec.l4_second = {16'b0, snap_i.l4w[6], snap_i.l4w[7]};
            end
          end
        end
        default: begin
          if (got_f(snap_i.cnt, l4o, 3'd4)) begin
            rec.l4_ident = {snap_i.l4w[0], snap_i.l4w[1], snap_i.l4w[2], snap_i.l4w[3]};
          end
          if (got_f(snap_i.cnt, l4o + 8'd4, 3'd4)) begin
            rec.l4_second = {snap_i.l4w[4], snap_i.l4w[5], snap_i.l4w[6], snap_i.l4w[7]};
          end
        end
      endcase
    end

    rec_o = rec;
  end

endmodule
